// ----- hdl/lavm_pkg.sv -----
// Shared types, widths and helpers for the look-at view matrix block.
// No dependencies; every other file imports this package.
package lavm_pkg;

    localparam int W      = 32;  // Q16.16 field width
    localparam int D_W    = 33;  // focus minus eye
    localparam int AX_W   = 19;  // axis components (n, u, v)
    localparam int PR_W   = AX_W + W;
    localparam int ACC_W  = 52;  // cross and dot accumulators
    localparam int NV_W   = 50;  // normalizer input
    localparam int SUM_W  = 62;  // sum of squares after block scaling
    localparam int ROOT_W = 31;
    localparam int Q_W    = 17;  // quotient bits of one division

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] ROW_U = 2'd0;
    localparam logic [1:0] ROW_V = 2'd1;
    localparam logic [1:0] ROW_N = 2'd2;

    typedef logic signed [W-1:0] q16_t;

    typedef struct packed {
        q16_t eye_x;
        q16_t eye_y;
        q16_t eye_z;
        q16_t focus_x;
        q16_t focus_y;
        q16_t focus_z;
    } item_t;

    typedef struct packed {
        logic [1:0] row_index;
        q16_t       col_x;
        q16_t       col_y;
        q16_t       col_z;
        q16_t       translation;
        logic       degenerate;
        logic       last_row;
    } result_t;

    typedef struct packed {
        q16_t                  eye_x;
        q16_t                  eye_y;
        q16_t                  eye_z;
        logic signed [D_W-1:0] d_x;
        logic signed [D_W-1:0] d_y;
        logic signed [D_W-1:0] d_z;
        logic                  d_zero;
    } job_t;

    typedef struct packed {
        logic done;
        logic zero;
    } norm_stat_t;

    // Q32.32 to Q16.16, ties away from zero.
    function automatic logic signed [ACC_W-1:0] rnd16(input logic signed [ACC_W-1:0] x);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] m;
        mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
        m   = (mag + ACC_W'(32'h8000)) >> 16;
        return x[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [1:0] nx1(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd1;
            2'd1:    return 2'd2;
            default: return 2'd0;
        endcase
    endfunction

    function automatic logic [1:0] nx2(input logic [1:0] k);
        case (k)
            2'd0:    return 2'd2;
            2'd1:    return 2'd0;
            default: return 2'd1;
        endcase
    endfunction

endpackage

// ----- hdl/lavm_front.sv -----
// Front end: takes an item, forms focus minus eye and flags a zero direction.
// Depends on lavm_pkg.
module lavm_front import lavm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  item_t item,
    output logic  push,
    output job_t  job,
    input  logic  q_full
);

    logic                  valid_reg;
    job_t                  job_reg;
    job_t                  job_next;
    logic                  accept;
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic signed [D_W-1:0] dz;

    assign push   = valid_reg && !q_full;
    assign busy   = valid_reg && q_full;
    assign accept = start && !busy;
    assign job    = job_reg;

    always_comb
    begin
        dx = {item.focus_x[W-1], item.focus_x} - {item.eye_x[W-1], item.eye_x};
        dy = {item.focus_y[W-1], item.focus_y} - {item.eye_y[W-1], item.eye_y};
        dz = {item.focus_z[W-1], item.focus_z} - {item.eye_z[W-1], item.eye_z};
        job_next.eye_x  = item.eye_x;
        job_next.eye_y  = item.eye_y;
        job_next.eye_z  = item.eye_z;
        job_next.d_x    = dx;
        job_next.d_y    = dy;
        job_next.d_z    = dz;
        job_next.d_zero = (dx == '0) && (dy == '0) && (dz == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            valid_reg <= 1'b1;
        end
        else if (push)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ----- hdl/lavm_fifo.sv -----
// Short queue of prepared items between the front end and the back end.
// Depends on lavm_pkg.
module lavm_fifo import lavm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t wdata,
    output logic full,
    input  logic pop,
    output job_t rdata,
    output logic empty
);

    job_t               mem [0:Q_DEPTH-1];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full  = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- hdl/lavm_norm.sv -----
// Vector normalizer: block scaling, bit-serial square root, bit-serial divides.
// Depends on lavm_pkg.
module lavm_norm import lavm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [NV_W-1:0] vec_x,
    input  logic signed [NV_W-1:0] vec_y,
    input  logic signed [NV_W-1:0] vec_z,
    output norm_stat_t             stat,
    output logic signed [AX_W-1:0] res_x,
    output logic signed [AX_W-1:0] res_y,
    output logic signed [AX_W-1:0] res_z
);

    typedef enum logic [2:0] {
        N_IDLE,
        N_SCALE,
        N_SQ,
        N_SQRT,
        N_DLD,
        N_DRUN
    } nstate_t;

    nstate_t                 state_reg;
    norm_stat_t              stat_reg;
    logic [NV_W-1:0]         m_reg [0:2];
    logic                    neg_reg [0:2];
    logic [SUM_W-1:0]        s_reg;
    logic [59:0]             sq_prod_reg;
    logic [4:0]              cnt_reg;
    logic [ROOT_W+4:0]       rem_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [ROOT_W:0]         drem_reg;
    logic [Q_W-1:0]          dq_reg;
    logic [1:0]              idx_reg;
    logic signed [AX_W-1:0]  res_reg [0:2];

    logic [NV_W-1:0]   mx;
    logic [29:0]       sq_op;
    logic [59:0]       sq_w;
    logic [ROOT_W+4:0] rem_sh;
    logic [ROOT_W+4:0] trial;
    logic              ge;
    logic [46:0]       num;
    logic [ROOT_W:0]   drem_sh;
    logic              dge;
    logic [Q_W-1:0]    q;

    assign stat  = stat_reg;
    assign res_x = res_reg[0];
    assign res_y = res_reg[1];
    assign res_z = res_reg[2];

    always_comb
    begin
        mx = m_reg[0];
        if (m_reg[1] > mx)
        begin
            mx = m_reg[1];
        end
        if (m_reg[2] > mx)
        begin
            mx = m_reg[2];
        end
        sq_op   = (cnt_reg[1:0] == 2'd3) ? '0 : m_reg[cnt_reg[1:0]][29:0];
        sq_w    = sq_op * sq_op;
        rem_sh  = {rem_reg[ROOT_W+2:0], s_reg[SUM_W-1 -: 2]};
        trial   = {3'b000, root_reg, 2'b01};
        ge      = (rem_sh >= trial);
        num     = {1'b0, m_reg[idx_reg][29:0], 16'h0000} + {17'h00000, root_reg[ROOT_W-1:1]};
        drem_sh = {drem_reg[ROOT_W-1:0], dq_reg[Q_W-1]};
        dge     = (drem_sh >= {1'b0, root_reg});
        q       = {dq_reg[Q_W-2:0], dge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
            stat_reg  <= '0;
        end
        else
        begin
            stat_reg <= '0;
            case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= N_SCALE;
                    end
                end
                N_SCALE:
                begin
                    if (mx == '0)
                    begin
                        stat_reg  <= '{done: 1'b1, zero: 1'b1};
                        state_reg <= N_IDLE;
                    end
                    else if (mx[29] && mx[NV_W-1:30] == '0)
                    begin
                        state_reg <= N_SQ;
                    end
                end
                N_SQ:
                begin
                    if (cnt_reg[1:0] == 2'd3)
                    begin
                        state_reg <= N_SQRT;
                    end
                end
                N_SQRT:
                begin
                    if (cnt_reg == 5'(ROOT_W - 1))
                    begin
                        state_reg <= N_DLD;
                    end
                end
                N_DLD:
                begin
                    state_reg <= N_DRUN;
                end
                N_DRUN:
                begin
                    if (cnt_reg == 5'(Q_W - 1))
                    begin
                        if (idx_reg == 2'd2)
                        begin
                            stat_reg  <= '{done: 1'b1, zero: 1'b0};
                            state_reg <= N_IDLE;
                        end
                        else
                        begin
                            state_reg <= N_DLD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; the scaling steps by eight are exact because
    // truncating shifts compose.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            N_IDLE:
            begin
                if (start)
                begin
                    m_reg[0]   <= vec_x[NV_W-1] ? NV_W'(-vec_x) : NV_W'(vec_x);
                    m_reg[1]   <= vec_y[NV_W-1] ? NV_W'(-vec_y) : NV_W'(vec_y);
                    m_reg[2]   <= vec_z[NV_W-1] ? NV_W'(-vec_z) : NV_W'(vec_z);
                    neg_reg[0] <= vec_x[NV_W-1];
                    neg_reg[1] <= vec_y[NV_W-1];
                    neg_reg[2] <= vec_z[NV_W-1];
                end
            end
            N_SCALE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (mx[NV_W-1:38] != '0)
                    begin
                        m_reg[i] <= m_reg[i] >> 8;
                    end
                    else if (mx[NV_W-1:30] != '0)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                    else if (mx[NV_W-1:21] == '0)
                    begin
                        m_reg[i] <= m_reg[i] << 8;
                    end
                    else if (mx[NV_W-1:29] == '0)
                    begin
                        m_reg[i] <= m_reg[i] << 1;
                    end
                end
                s_reg   <= '0;
                cnt_reg <= '0;
            end
            N_SQ:
            begin
                sq_prod_reg <= sq_w;
                if (cnt_reg[1:0] != 2'd0)
                begin
                    s_reg <= s_reg + SUM_W'(sq_prod_reg);
                end
                cnt_reg  <= (cnt_reg[1:0] == 2'd3) ? '0 : cnt_reg + 1'b1;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            N_SQRT:
            begin
                s_reg    <= s_reg << 2;
                rem_reg  <= ge ? rem_sh - trial : rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], ge};
                cnt_reg  <= (cnt_reg == 5'(ROOT_W - 1)) ? '0 : cnt_reg + 1'b1;
                idx_reg  <= '0;
            end
            N_DLD:
            begin
                drem_reg <= {2'b00, num[46:Q_W]};
                dq_reg   <= num[Q_W-1:0];
                cnt_reg  <= '0;
            end
            N_DRUN:
            begin
                drem_reg <= dge ? drem_sh - {1'b0, root_reg} : drem_sh;
                dq_reg   <= q;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == 5'(Q_W - 1))
                begin
                    res_reg[idx_reg] <= neg_reg[idx_reg] ? -$signed({2'b00, q})
                                                         : $signed({2'b00, q});
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- hdl/lavm_back.sv -----
// Back end: runs normalizations, cross and dot products, and emits the rows.
// Depends on lavm_pkg and lavm_norm.
module lavm_back import lavm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_empty,
    input  job_t    q_data,
    output logic    q_pop,
    input  q16_t    up_x,
    input  q16_t    up_y,
    input  q16_t    up_z,
    output logic    strobe,
    output result_t result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_N1,
        S_MUL,
        S_ACC,
        S_N2GO,
        S_N2,
        S_VRND,
        S_ROW,
        S_DEG
    } state_t;

    typedef enum logic [1:0] {
        M_CUP,
        M_CU,
        M_DOT
    } mode_t;

    state_t                  state_reg;
    mode_t                   mode_reg;
    logic [2:0]              op_reg;
    logic [1:0]              row_reg;
    q16_t                    eye_reg [0:2];
    logic signed [AX_W-1:0]  n_reg [0:2];
    logic signed [AX_W-1:0]  u_reg [0:2];
    logic signed [AX_W-1:0]  v_reg [0:2];
    logic signed [ACC_W-1:0] acc_reg [0:2];
    logic signed [PR_W-1:0]  prod_reg;
    logic                    strobe_reg;
    result_t                 result_reg;

    q16_t                    up_v [0:2];
    logic signed [AX_W-1:0]  axis [0:2];
    logic [1:0]              k;
    logic [1:0]              ia;
    logic [1:0]              ib;
    logic [1:0]              ai;
    logic signed [AX_W-1:0]  op_a;
    q16_t                    op_b;
    logic signed [PR_W-1:0]  mul_w;
    logic signed [ACC_W-1:0] prod_ext;
    logic signed [ACC_W-1:0] acc_add;
    logic                    last_op;
    logic signed [ACC_W-1:0] tr;
    q16_t                    trans;

    logic                    norm_start;
    logic signed [NV_W-1:0]  nv_x;
    logic signed [NV_W-1:0]  nv_y;
    logic signed [NV_W-1:0]  nv_z;
    norm_stat_t              stat;
    logic signed [AX_W-1:0]  res_x;
    logic signed [AX_W-1:0]  res_y;
    logic signed [AX_W-1:0]  res_z;

    assign strobe = strobe_reg;
    assign result = result_reg;
    assign q_pop  = (state_reg == S_IDLE) && !q_empty;

    assign up_v[0] = up_x;
    assign up_v[1] = up_y;
    assign up_v[2] = up_z;

    always_comb
    begin
        case (row_reg)
            ROW_U:   axis = u_reg;
            ROW_V:   axis = v_reg;
            default: axis = n_reg;
        endcase
        k  = op_reg[2:1];
        ia = op_reg[0] ? nx2(k) : nx1(k);
        ib = op_reg[0] ? nx1(k) : nx2(k);
        case (mode_reg)
            M_CUP:
            begin
                op_a = n_reg[ia];
                op_b = up_v[ib];
            end
            M_CU:
            begin
                op_a = n_reg[ia];
                op_b = {{(W-AX_W){u_reg[ib][AX_W-1]}}, u_reg[ib]};
            end
            default:
            begin
                op_a = axis[op_reg[1:0]];
                op_b = eye_reg[op_reg[1:0]];
            end
        endcase
        mul_w    = op_a * op_b;
        prod_ext = {{(ACC_W-PR_W){prod_reg[PR_W-1]}}, prod_reg};
        ai       = (mode_reg == M_DOT) ? 2'd0 : k;
        // The second product of each cross component is subtracted.
        acc_add  = (mode_reg != M_DOT && op_reg[0]) ? acc_reg[ai] - prod_ext
                                                    : acc_reg[ai] + prod_ext;
        last_op  = (mode_reg == M_DOT) ? (op_reg == 3'd2) : (op_reg == 3'd5);

        tr = rnd16(-acc_reg[0]);
        if (tr[ACC_W-1:W-1] != '0 && tr[ACC_W-1:W-1] != '1)
        begin
            trans = tr[ACC_W-1] ? q16_t'(32'h8000_0000) : q16_t'(32'h7FFF_FFFF);
        end
        else
        begin
            trans = tr[W-1:0];
        end

        norm_start = (q_pop && !q_data.d_zero) || (state_reg == S_N2GO);
        if (state_reg == S_IDLE)
        begin
            nv_x = {{(NV_W-D_W){q_data.d_x[D_W-1]}}, q_data.d_x};
            nv_y = {{(NV_W-D_W){q_data.d_y[D_W-1]}}, q_data.d_y};
            nv_z = {{(NV_W-D_W){q_data.d_z[D_W-1]}}, q_data.d_z};
        end
        else
        begin
            nv_x = acc_reg[0][NV_W-1:0];
            nv_y = acc_reg[1][NV_W-1:0];
            nv_z = acc_reg[2][NV_W-1:0];
        end
    end

    lavm_norm u_norm
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (norm_start),
        .vec_x (nv_x),
        .vec_y (nv_y),
        .vec_z (nv_z),
        .stat  (stat),
        .res_x (res_x),
        .res_y (res_y),
        .res_z (res_z)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        state_reg <= q_data.d_zero ? S_DEG : S_N1;
                    end
                end
                S_N1:
                begin
                    if (stat.done)
                    begin
                        state_reg <= stat.zero ? S_DEG : S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    if (!last_op)
                    begin
                        state_reg <= S_MUL;
                    end
                    else
                    begin
                        case (mode_reg)
                            M_CUP:   state_reg <= S_N2GO;
                            M_CU:    state_reg <= S_VRND;
                            default: state_reg <= S_ROW;
                        endcase
                    end
                end
                S_N2GO:
                begin
                    state_reg <= S_N2;
                end
                S_N2:
                begin
                    if (stat.done)
                    begin
                        state_reg <= stat.zero ? S_DEG : S_MUL;
                    end
                end
                S_VRND:
                begin
                    state_reg <= S_MUL;
                end
                S_ROW:
                begin
                    strobe_reg <= 1'b1;
                    state_reg  <= (row_reg == ROW_N) ? S_IDLE : S_MUL;
                end
                S_DEG:
                begin
                    strobe_reg <= 1'b1;
                    if (row_reg == ROW_N)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                eye_reg[0] <= q_data.eye_x;
                eye_reg[1] <= q_data.eye_y;
                eye_reg[2] <= q_data.eye_z;
                row_reg    <= ROW_U;
            end
            S_N1:
            begin
                n_reg[0] <= res_x;
                n_reg[1] <= res_y;
                n_reg[2] <= res_z;
                mode_reg <= M_CUP;
                op_reg   <= '0;
                acc_reg  <= '{default: '0};
            end
            S_MUL:
            begin
                prod_reg <= mul_w;
            end
            S_ACC:
            begin
                acc_reg[ai] <= acc_add;
                op_reg      <= op_reg + 1'b1;
            end
            S_N2:
            begin
                u_reg[0] <= res_x;
                u_reg[1] <= res_y;
                u_reg[2] <= res_z;
                mode_reg <= M_CU;
                op_reg   <= '0;
                acc_reg  <= '{default: '0};
            end
            S_VRND:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    v_reg[i] <= AX_W'(rnd16(acc_reg[i]));
                end
                mode_reg <= M_DOT;
                op_reg   <= '0;
                row_reg  <= ROW_U;
                acc_reg  <= '{default: '0};
            end
            S_ROW:
            begin
                result_reg.row_index   <= row_reg;
                result_reg.col_x       <= {{(W-AX_W){axis[0][AX_W-1]}}, axis[0]};
                result_reg.col_y       <= {{(W-AX_W){axis[1][AX_W-1]}}, axis[1]};
                result_reg.col_z       <= {{(W-AX_W){axis[2][AX_W-1]}}, axis[2]};
                result_reg.translation <= trans;
                result_reg.degenerate  <= 1'b0;
                result_reg.last_row    <= (row_reg == ROW_N);
                row_reg                <= row_reg + 1'b1;
                op_reg                 <= '0;
                acc_reg                <= '{default: '0};
            end
            S_DEG:
            begin
                result_reg.row_index   <= row_reg;
                result_reg.col_x       <= '0;
                result_reg.col_y       <= '0;
                result_reg.col_z       <= '0;
                result_reg.translation <= '0;
                result_reg.degenerate  <= 1'b1;
                result_reg.last_row    <= (row_reg == ROW_N);
                row_reg                <= row_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && result_reg.degenerate |->
            result_reg.col_x == '0 && result_reg.col_y == '0 &&
            result_reg.col_z == '0 && result_reg.translation == '0)
        else $error("degenerate row carries nonzero data");

    a_norm_wait: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == S_N1 || state_reg == S_N2))
        else $error("normalizer finished while nobody waited");

    a_rows_go_on: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg && !result_reg.last_row |-> state_reg != S_IDLE)
        else $error("item dropped before its last row");
`endif

endmodule

// ----- hdl/look_at_view_matrix.sv -----
// Top level of the look-at view matrix block: config registers, front end,
// queue and back end. Depends on lavm_pkg, lavm_front, lavm_fifo, lavm_back.
//
//  channel   handshake                  payload
//  item      start in, busy out         item (item_t)
//  result    strobe out, no back-press  result (result_t), three per item
//  config    APB psel/penable/pwrite    up_x @0, up_y @4, up_z @8
//
// In the back end the normalizer runs at most twice per item, each time with
// a 31-step square root and three 17-step divides. A degenerate direction
// yields its three rows back to back. The front stage and a two-entry queue
// take further items while one runs; busy rises only when both are full.
// Reset clears the state registers, queue pointers and strobes.
module look_at_view_matrix import lavm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  item_t       item,
    output logic        strobe,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_UP_X = 2'd0;
    localparam logic [1:0] REG_UP_Y = 2'd1;
    localparam logic [1:0] REG_UP_Z = 2'd2;

    q16_t up_x_reg;
    q16_t up_y_reg;
    q16_t up_z_reg;
    logic wr_en;
    logic push;
    job_t job;
    logic q_full;
    logic q_pop;
    job_t q_data;
    logic q_empty;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[3:2])
            REG_UP_X: prdata = up_x_reg;
            REG_UP_Y: prdata = up_y_reg;
            REG_UP_Z: prdata = up_z_reg;
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_x_reg <= '0;
            up_y_reg <= '0;
            up_z_reg <= q16_t'(32'h0001_0000);
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_UP_X: up_x_reg <= pwdata;
                REG_UP_Y: up_y_reg <= pwdata;
                REG_UP_Z: up_z_reg <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    lavm_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .push   (push),
        .job    (job),
        .q_full (q_full)
    );

    lavm_fifo u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (job),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_data),
        .empty (q_empty)
    );

    lavm_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .up_x    (up_x_reg),
        .up_y    (up_y_reg),
        .up_z    (up_z_reg),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

// ----- test/look_at_view_matrix_tb.sv -----
// Self-checking testbench for the look-at view matrix block: random and directed
// eye/focus items, up vector written over APB, rows checked against a local predictor.
// Depends on lavm_pkg and look_at_view_matrix.
module look_at_view_matrix_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lavm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_BOTH} idle_mode_e;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    item_t       item;
    logic        strobe;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    look_at_view_matrix DUT (.*);

    item_t      pending_items[$];
    result_t    expected_rows[$];
    q16_t       shadow_up[3];
    idle_mode_e idle_mode;
    int         error_count;
    int         items_sent;
    int         rows_checked;
    int         degenerate_rows;
    int         quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h (row %0d)", what, got, want, rows_checked);
        error_count++;
    endtask

    function automatic longint unsigned root_floor(input longint unsigned s);
        longint unsigned res;
        longint unsigned probe;
        res   = 0;
        probe = 64'd1 << 62;
        while (probe > s)
            probe >>= 2;
        while (probe != 0)
        begin
            if (s >= res + probe)
            begin
                s   = s - (res + probe);
                res = (res >> 1) + probe;
            end
            else
                res >>= 1;
            probe >>= 2;
        end
        return res;
    endfunction

    function automatic longint round_q16(input longint x);
        longint unsigned m;
        m = ((x < 0) ? -x : x);
        m = (m + 64'h8000) >> 16;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    // Block-scale to [2^29, 2^30), then divide each magnitude by the root.
    function automatic bit unit_vector(input longint v[3], output longint o[3]);
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned s;
        longint unsigned r;
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = (v[i] < 0) ? -v[i] : v[i];
            if (m[i] > mx)
                mx = m[i];
            o[i] = 0;
        end
        if (mx == 0)
            return 1'b0;
        while (mx >= (64'd1 << 30))
        begin
            for (int i = 0; i < 3; i++)
                m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29))
        begin
            for (int i = 0; i < 3; i++)
                m[i] <<= 1;
            mx <<= 1;
        end
        s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        r = root_floor(s);
        for (int i = 0; i < 3; i++)
        begin
            o[i] = longint'(((m[i] << 16) + r / 2) / r);
            if (v[i] < 0)
                o[i] = -o[i];
        end
        return 1'b1;
    endfunction

    function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
        o[0] = a[1] * b[2] - a[2] * b[1];
        o[1] = a[2] * b[0] - a[0] * b[2];
        o[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    task automatic predict_rows(input item_t it);
        longint eye[3], d[3], up[3], n[3], c[3], u[3], vr[3], v[3], ax[3];
        longint t;
        bit ok;
        result_t row;
        eye[0] = it.eye_x;
        eye[1] = it.eye_y;
        eye[2] = it.eye_z;
        d[0] = longint'(it.focus_x) - eye[0];
        d[1] = longint'(it.focus_y) - eye[1];
        d[2] = longint'(it.focus_z) - eye[2];
        for (int i = 0; i < 3; i++)
            up[i] = shadow_up[i];
        ok = unit_vector(d, n);
        if (ok)
        begin
            cross3(n, up, c);
            ok = unit_vector(c, u);
        end
        if (ok)
        begin
            cross3(n, u, vr);
            for (int i = 0; i < 3; i++)
                v[i] = round_q16(vr[i]);
        end
        for (int k = 0; k < 3; k++)
        begin
            row = '0;
            row.row_index = 2'(k);
            row.last_row  = (k == 2);
            if (ok)
            begin
                for (int i = 0; i < 3; i++)
                    ax[i] = (k == 0) ? u[i] : (k == 1) ? v[i] : n[i];
                t = round_q16(-(ax[0] * eye[0] + ax[1] * eye[1] + ax[2] * eye[2]));
                if (t > 64'sd2147483647)
                    t = 64'sd2147483647;
                if (t < -64'sd2147483648)
                    t = -64'sd2147483648;
                row.col_x       = q16_t'(ax[0]);
                row.col_y       = q16_t'(ax[1]);
                row.col_z       = q16_t'(ax[2]);
                row.translation = q16_t'(t);
            end
            else
                row.degenerate = 1'b1;
            expected_rows.push_back(row);
        end
    endtask

    // Driver: an item is taken at an edge with start high and busy low.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                predict_rows(item);
                items_sent++;
            end
            if (start && busy)
                start <= 1'b1;
            else if (pending_items.size() != 0 &&
                     !(idle_mode == IDLE_SENDER && $urandom_range(99) < 66) &&
                     !(idle_mode == IDLE_BOTH && $urandom_range(99) < 25))
            begin
                start <= 1'b1;
                item  <= pending_items.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: every strobed row is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            if (expected_rows.size() == 0)
            begin
                report_mismatch("unexpected row", 32'(result.row_index), 32'h0);
            end
            else
            begin
                result_t want;
                want = expected_rows.pop_front();
                if (result.row_index != want.row_index)
                    report_mismatch("row_index", result.row_index, want.row_index);
                if (result.col_x != want.col_x)
                    report_mismatch("col_x", result.col_x, want.col_x);
                if (result.col_y != want.col_y)
                    report_mismatch("col_y", result.col_y, want.col_y);
                if (result.col_z != want.col_z)
                    report_mismatch("col_z", result.col_z, want.col_z);
                if (result.translation != want.translation)
                    report_mismatch("translation", result.translation, want.translation);
                if (result.degenerate != want.degenerate)
                    report_mismatch("degenerate", result.degenerate, want.degenerate);
                if (result.last_row != want.last_row)
                    report_mismatch("last_row", result.last_row, want.last_row);
                if (want.degenerate)
                    degenerate_rows++;
                rows_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || strobe)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d rows outstanding", expected_rows.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_up(input int idx, input q16_t value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= 4'(4 * idx);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        shadow_up[idx] = value;
    endtask

    task automatic set_up(input q16_t x, input q16_t y, input q16_t z);
        write_up(0, x);
        write_up(1, y);
        write_up(2, z);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_items.size() != 0 || start || expected_rows.size() != 0);
    endtask

    function automatic q16_t rand_field(input bit narrow);
        if (narrow)
            return q16_t'(int'($urandom_range(0, 2097152)) - 1048576);
        return q16_t'($urandom);
    endfunction

    function automatic item_t rand_item();
        item_t it;
        int    pick;
        int    scale;
        bit    narrow;
        pick   = $urandom_range(99);
        narrow = (pick >= 60);
        it.eye_x   = rand_field(narrow);
        it.eye_y   = rand_field(narrow);
        it.eye_z   = rand_field(narrow);
        it.focus_x = rand_field(narrow);
        it.focus_y = rand_field(narrow);
        it.focus_z = rand_field(narrow);
        if (pick >= 80 && pick < 90)
        begin
            it.focus_x = it.eye_x;
            it.focus_y = it.eye_y;
            it.focus_z = it.eye_z;
        end
        else if (pick >= 90)
        begin
            // Look straight along the up vector, scaled by a small factor.
            scale = int'($urandom_range(0, 6)) - 3;
            it.focus_x = it.eye_x + scale * shadow_up[0];
            it.focus_y = it.eye_y + scale * shadow_up[1];
            it.focus_z = it.eye_z + scale * shadow_up[2];
        end
        return it;
    endfunction

    task automatic run_random(input int count, input idle_mode_e mode);
        idle_mode = mode;
        repeat (count)
            pending_items.push_back(rand_item());
        wait_drained();
    endtask

    function automatic item_t make_item(input q16_t ex, input q16_t ey, input q16_t ez,
                                        input q16_t fx, input q16_t fy, input q16_t fz);
        item_t it;
        it.eye_x   = ex;
        it.eye_y   = ey;
        it.eye_z   = ez;
        it.focus_x = fx;
        it.focus_y = fy;
        it.focus_z = fz;
        return it;
    endfunction

    localparam q16_t QMAX = 32'sh7fffffff;
    localparam q16_t QMIN = 32'sh80000000;
    localparam q16_t ONE  = 32'sh00010000;

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        item    = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        idle_mode       = IDLE_NONE;
        error_count     = 0;
        items_sent      = 0;
        rows_checked    = 0;
        degenerate_rows = 0;
        quiet_cycles    = 0;
        shadow_up[0] = 0;
        shadow_up[1] = 0;
        shadow_up[2] = ONE;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed items with the up vector left at its reset value.
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE));
        pending_items.push_back(make_item(0, 0, 0, 0, 0, 5 * ONE));
        pending_items.push_back(make_item(0, 0, ONE, 0, 0, -ONE));
        pending_items.push_back(make_item(0, 0, 0, ONE, 0, 0));
        pending_items.push_back(make_item(5 * ONE, 5 * ONE, 5 * ONE, 0, 0, 0));
        pending_items.push_back(make_item(QMIN, QMIN, QMIN, QMAX, QMAX, QMAX));
        pending_items.push_back(make_item(QMAX, QMAX, QMAX, QMIN, QMIN, QMIN));
        pending_items.push_back(make_item(QMAX, QMIN, QMAX, QMIN, QMAX, QMIN));
        pending_items.push_back(make_item(QMIN, 0, QMAX, QMAX, 1, QMIN));
        pending_items.push_back(make_item(1, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(-1, -1, -1, 0, 0, 0));
        pending_items.push_back(make_item(QMAX, QMAX, QMAX, QMAX, QMAX, QMIN));
        pending_items.push_back(make_item(-32'sd1, 0, 0, QMAX, 0, 0));
        wait_drained();
        run_random(70, IDLE_NONE);

        set_up(0, ONE, 0);
        pending_items.push_back(make_item(0, 0, 0, 0, 3 * ONE, 0));
        run_random(70, IDLE_SENDER);

        set_up(QMAX, QMAX, QMAX);
        pending_items.push_back(make_item(0, 0, 0, 7, 7, 7));
        run_random(70, IDLE_BOTH);

        set_up(QMIN, QMIN, QMIN);
        run_random(60, IDLE_SENDER);

        set_up(0, 0, 0);
        run_random(15, IDLE_NONE);

        set_up(q16_t'($urandom), q16_t'($urandom), q16_t'($urandom));
        run_random(60, IDLE_BOTH);

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d items over six up-vector settings with varied sender gaps.",
                 items_sent);
        $display("Checked %0d rows, %0d of them degenerate; %0d mismatches.",
                 rows_checked, degenerate_rows, error_count);
        if (error_count == 0 && expected_rows.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
